[rtl/tdd_pkg.sv]
// Shared types and constants for the doorway direction detector.
// Holds the transaction payload structs, register indexes and event codes.
// No dependencies.
package tdd_pkg;

   localparam int unsigned PIXELS_PER_ZONE = 8;
   localparam int unsigned HISTORY_LEN     = 5;
   // Number of 2-bit entries carried by each pattern register.
   localparam int unsigned PATTERN_ENTRIES = 5;

   localparam int unsigned DIST_WIDTH    = 12;
   localparam int unsigned PIXEL_WIDTH   = 4;
   localparam int unsigned PATTERN_WIDTH = 2 * PATTERN_ENTRIES;
   localparam int unsigned PTR_WIDTH     = $clog2(HISTORY_LEN);
   // Wide enough to compare a pixel index against twice the largest zone size.
   localparam int unsigned PIX_CMP_WIDTH = 8;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 12;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISTANCE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENTER_PATTERN      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXIT_PATTERN       = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEFAULT_PATTERN    = 2'd3;

   localparam logic [DIST_WIDTH-1:0]    THRESHOLD_RESET = 12'd1000;
   localparam logic [PATTERN_WIDTH-1:0] ENTER_RESET     = 10'd180;
   localparam logic [PATTERN_WIDTH-1:0] EXIT_RESET      = 10'd120;
   localparam logic [PATTERN_WIDTH-1:0] DEFAULT_RESET   = 10'd0;

   localparam logic [1:0] EVENT_NONE  = 2'd0;
   localparam logic [1:0] EVENT_ENTER = 2'd1;
   localparam logic [1:0] EVENT_EXIT  = 2'd2;

   localparam logic [1:0] ZONE_EMPTY = 2'd0;

   typedef struct packed {
      logic [DIST_WIDTH-1:0]  range_mm;
      logic [PIXEL_WIDTH-1:0] pixel_index;
      logic                   frame_end;
   } req_data_type;

   typedef struct packed {
      logic [1:0] crossing_event;
      logic [1:0] zone_code;
   } rsp_data_type;

   typedef logic [1:0] zone_type;

   // Entry k of a pattern register; entries beyond the register read as empty.
   function automatic zone_type pattern_entry(input logic [PATTERN_WIDTH-1:0] pat,
                                              input int unsigned k);
      zone_type entry;
      entry = ZONE_EMPTY;
      if (k < PATTERN_ENTRIES) begin
         entry = pat[2*k +: 2];
      end
      return entry;
   endfunction

endpackage

[rtl/tof_doorway_direction_detector_core.sv]
// Top level of the doorway direction detector.
// Depends on tdd_pkg for payload types, register indexes and event codes.
//
// Usage: one transaction on the req_ channel carries one pixel distance of a
// two-zone time-of-flight frame, with frame_end set on the frame's last pixel.
// Pixels in the lower half of the index range mark the left zone, the upper
// half the right zone, when nearer than distance_threshold. Only a frame_end
// transaction yields a rsp_ transaction: the frame's zone code and any enter
// or exit crossing found in the zone history when the doorway becomes empty.
// A pixel is taken into an input register on acceptance and is evaluated
// against the history from there; the result of a frame_end pixel is then
// registered in the output register and offered on rsp_. One pixel is
// accepted in every cycle, limited only by the output register: when the
// receiver stalls and a result is waiting, a pending frame_end pixel holds
// in the input register and req_stall rises. Pixels without frame_end never
// wait. The csr_ channel is always ready; the user must write registers only
// while the block is idle, which the block itself does not enforce. Reset
// restores the register defaults, empties the history, sets the history
// pointer to one and drops any transaction in flight.
module tof_doorway_direction_detector_core
   import tdd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_data_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_data_type               rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // Configuration registers.
   logic [DIST_WIDTH-1:0]    threshold_ff;
   logic [PATTERN_WIDTH-1:0] enter_ff;
   logic [PATTERN_WIDTH-1:0] exit_ff;
   logic [PATTERN_WIDTH-1:0] default_ff;

   // Input register.
   logic         in_valid_ff;
   req_data_type in_data_ff;

   // Detector state.
   zone_type               hist_ff [HISTORY_LEN];
   zone_type               hist_in [HISTORY_LEN];
   logic [PTR_WIDTH-1:0]   ptr_ff;
   logic [PTR_WIDTH-1:0]   ptr_in;
   logic                   left_ff;
   logic                   left_in;
   logic                   right_ff;
   logic                   right_in;

   // Output register.
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_data_type out_data_ff;
   rsp_data_type out_data_in;

   logic                     req_accept;
   logic                     out_free;
   logic                     proc_go;
   logic                     near;
   logic [PIX_CMP_WIDTH-1:0] pix_wide;
   logic                     hit_left;
   logic                     hit_right;
   logic                     frame_left;
   logic                     frame_right;
   zone_type                 code;
   logic [PTR_WIDTH-1:0]     prev_idx;
   logic [PTR_WIDTH-1:0]     ptr_next;
   logic                     code_changed;
   logic                     enter_match;
   logic                     exit_match;
   logic [1:0]               event_code;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         enter_ff     <= ENTER_RESET;
         exit_ff      <= EXIT_RESET;
         default_ff   <= DEFAULT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DISTANCE_THRESHOLD: threshold_ff <= csr_data[DIST_WIDTH-1:0];
            CSR_ENTER_PATTERN:      enter_ff     <= csr_data[PATTERN_WIDTH-1:0];
            CSR_EXIT_PATTERN:       exit_ff      <= csr_data[PATTERN_WIDTH-1:0];
            CSR_DEFAULT_PATTERN:    default_ff   <= csr_data[PATTERN_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // A pixel without frame_end produces no result and so never needs the
   // output register; a frame_end pixel waits until the register is free.
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign proc_go    = in_valid_ff && (!in_data_ff.frame_end || out_free);
   assign req_stall  = in_valid_ff && !proc_go;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || proc_go) begin
         in_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
   end

   // Zone occupancy for the registered pixel; indexes past both zones mark
   // nothing but a frame_end on them still closes the frame.
   assign pix_wide    = PIX_CMP_WIDTH'(in_data_ff.pixel_index);
   assign near        = in_data_ff.range_mm < threshold_ff;
   assign hit_left    = near && (pix_wide < PIX_CMP_WIDTH'(PIXELS_PER_ZONE));
   assign hit_right   = near && !hit_left
                        && (pix_wide < PIX_CMP_WIDTH'(2 * PIXELS_PER_ZONE));
   assign frame_left  = left_ff || hit_left;
   assign frame_right = right_ff || hit_right;
   assign code        = {frame_right, frame_left};

   // The entry before the pointer wraps to the last slot at pointer zero.
   assign prev_idx = (ptr_ff == '0) ? PTR_WIDTH'(HISTORY_LEN - 1) : ptr_ff - 1'b1;
   assign ptr_next = (ptr_ff == PTR_WIDTH'(HISTORY_LEN - 1)) ? '0 : ptr_ff + 1'b1;
   assign code_changed = code != hist_ff[prev_idx];

   // Pattern compare runs on the history with the new empty code already
   // written at the pointer.
   always_comb begin
      zone_type probe;
      enter_match = 1'b1;
      exit_match  = 1'b1;
      for (int unsigned k = 0; k < HISTORY_LEN; k++) begin
         probe = (PTR_WIDTH'(k) == ptr_ff) ? code : hist_ff[k];
         if (probe != pattern_entry(enter_ff, k)) begin
            enter_match = 1'b0;
         end
         if (probe != pattern_entry(exit_ff, k)) begin
            exit_match = 1'b0;
         end
      end
   end

   always_comb begin
      hist_in    = hist_ff;
      ptr_in     = ptr_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      event_code = EVENT_NONE;
      if (proc_go) begin
         if (!in_data_ff.frame_end) begin
            left_in  = frame_left;
            right_in = frame_right;
         end else begin
            left_in  = 1'b0;
            right_in = 1'b0;
            if (code_changed) begin
               if (code == ZONE_EMPTY) begin
                  // Doorway is empty again: judge the crossing, then restart
                  // the history from the default pattern.
                  priority if (enter_match) begin
                     event_code = EVENT_ENTER;
                  end else if (exit_match) begin
                     event_code = EVENT_EXIT;
                  end else begin
                     event_code = EVENT_NONE;
                  end
                  for (int unsigned k = 0; k < HISTORY_LEN; k++) begin
                     hist_in[k] = pattern_entry(default_ff, k);
                  end
                  ptr_in = PTR_WIDTH'(1);
               end else begin
                  hist_in[ptr_ff] = code;
                  ptr_in          = ptr_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int unsigned k = 0; k < HISTORY_LEN; k++) begin
            hist_ff[k] <= ZONE_EMPTY;
         end
         ptr_ff   <= PTR_WIDTH'(1);
         left_ff  <= 1'b0;
         right_ff <= 1'b0;
      end else begin
         hist_ff  <= hist_in;
         ptr_ff   <= ptr_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   // Output register: loads a result on each processed frame_end pixel.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (proc_go && in_data_ff.frame_end) begin
         out_valid_in               = 1'b1;
         out_data_in.crossing_event = event_code;
         out_data_in.zone_code      = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[bench/tof_doorway_direction_detector_core_tb.sv]
// Self-checking testbench for tof_doorway_direction_detector_core.
// Depends on tdd_pkg and the core; drives pixel, register and result channels
// and checks every result against a cycle-free predictor of the detector.
`timescale 1ns / 100ps

module tof_doorway_direction_detector_core_tb;
   import tdd_pkg::*;

   // Zone codes beyond the empty one, as formed from the two near bits.
   localparam zone_type ZONE_LEFT  = 2'd1;
   localparam zone_type ZONE_RIGHT = 2'd2;
   localparam zone_type ZONE_BOTH  = 2'd3;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 3000;
   // A pixel is evaluated from the input register and its result leaves through
   // the output register, so the settle wait covers anything still in flight.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS  = 1130;
   localparam int PHASE_COUNT   = 6;

   // One row of the directed table: a pixel transaction and, where it is
   // obvious, the result that it must produce.
   typedef struct packed {
      req_data_type px;
      logic         fixed;
      rsp_data_type want;
   } stim_row_type;

   // The directed part runs with the register defaults: threshold 1000, enter
   // sequence empty-left-both-right-empty, exit sequence empty-right-both-
   // left-empty, and an empty default history.
   localparam stim_row_type DIRECTED [22] = '{
      // Just below the threshold counts, exactly at it does not.
      '{'{12'd999,  4'd0,  1'b0}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd1000, 4'd15, 1'b1}, 1'b1, '{EVENT_NONE,  ZONE_LEFT}},
      // Walk the enter sequence; the frame-end pixel itself is evaluated.
      '{'{12'd0,    4'd7,  1'b0}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd8,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd4095, 4'd0,  1'b0}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd15, 1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd4095, 4'd3,  1'b1}, 1'b1, '{EVENT_ENTER, ZONE_EMPTY}},
      // Walk the exit sequence.
      '{'{12'd0,    4'd12, 1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd0,  1'b0}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd9,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd5,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd4095, 4'd10, 1'b1}, 1'b1, '{EVENT_EXIT,  ZONE_EMPTY}},
      // A repeated code leaves the history alone and reports nothing.
      '{'{12'd0,    4'd2,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd6,  1'b1}, 1'b1, '{EVENT_NONE,  ZONE_LEFT}},
      '{'{12'd4095, 4'd0,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd4095, 4'd1,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      // Four alternating codes take the pointer round to zero, so the next
      // change compares against the last history entry.
      '{'{12'd0,    4'd8,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd0,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd15, 1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd7,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd0,    4'd9,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}},
      '{'{12'd4095, 4'd0,  1'b1}, 1'b0, '{EVENT_NONE,  ZONE_EMPTY}}
   };

   // Every input of the core starts from a known value, reset asserted.
   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_data_type               req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_data_type               rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   tof_doorway_direction_detector_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predictor state: its own copy of the registers and of the zone history.
   logic [DIST_WIDTH-1:0]    thr_q   = THRESHOLD_RESET;
   logic [PATTERN_WIDTH-1:0] enter_q = ENTER_RESET;
   logic [PATTERN_WIDTH-1:0] exit_q  = EXIT_RESET;
   logic [PATTERN_WIDTH-1:0] dflt_q  = DEFAULT_RESET;
   zone_type                 hist [HISTORY_LEN] = '{default: ZONE_EMPTY};
   int unsigned              hist_ptr   = 1;
   logic                     left_seen  = 1'b0;
   logic                     right_seen = 1'b0;

   rsp_data_type pending_results [$];
   rsp_data_type got_result;
   rsp_data_type want_result;

   bit idle_on       = 1'b1;
   int stall_run     = 0;
   int calm_run      = 0;
   int fail_count    = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int enters_seen   = 0;
   int exits_seen    = 0;
   int settings_used = 1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Failures are all counted; only the first few are described.
   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Two-bit entry k of a pattern register; entries past the register are empty.
   function automatic zone_type pattern_code(input logic [PATTERN_WIDTH-1:0] pat,
                                             input int unsigned k);
      if (k >= PATTERN_ENTRIES) begin
         return ZONE_EMPTY;
      end
      return pat[2*k +: 2];
   endfunction

   // Folds one accepted pixel into the predictor. Returns 1 and the expected
   // result when the pixel closes a frame.
   function automatic bit track_pixel(input req_data_type px, output rsp_data_type r);
      zone_type    code;
      int unsigned slot;
      int unsigned prev;
      bit          is_enter;
      bit          is_exit;
      r = '0;
      if (px.range_mm < thr_q) begin
         if (px.pixel_index < PIXELS_PER_ZONE) begin
            left_seen = 1'b1;
         end else if (px.pixel_index < 2 * PIXELS_PER_ZONE) begin
            right_seen = 1'b1;
         end
      end
      if (!px.frame_end) begin
         return 1'b0;
      end
      code       = {right_seen, left_seen};
      left_seen  = 1'b0;
      right_seen = 1'b0;
      r.zone_code      = code;
      r.crossing_event = EVENT_NONE;
      slot = hist_ptr % HISTORY_LEN;
      prev = (slot == 0) ? HISTORY_LEN - 1 : slot - 1;
      if (code != hist[prev]) begin
         hist[slot] = code;
         hist_ptr   = (slot + 1) % HISTORY_LEN;
         if (code == ZONE_EMPTY) begin
            is_enter = 1'b1;
            is_exit  = 1'b1;
            for (int k = 0; k < HISTORY_LEN; k++) begin
               if (hist[k] != pattern_code(enter_q, k)) is_enter = 1'b0;
               if (hist[k] != pattern_code(exit_q, k))  is_exit  = 1'b0;
            end
            // Enter wins when both sequences match.
            if (is_enter) begin
               r.crossing_event = EVENT_ENTER;
            end else if (is_exit) begin
               r.crossing_event = EVENT_EXIT;
            end
            for (int k = 0; k < HISTORY_LEN; k++) begin
               hist[k] = pattern_code(dflt_q, k);
            end
            hist_ptr = 1;
         end
      end
      return 1'b1;
   endfunction

   // Offers one pixel transaction, sometimes after a burst of idle cycles, and
   // returns at the edge where it is accepted. A fixed expectation from the
   // directed table replaces the predicted one.
   task automatic send_pixel(input req_data_type px, input logic fixed,
                             input rsp_data_type fixed_rsp);
      rsp_data_type r;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (track_pixel(px, r)) begin
         pending_results.push_back(fixed ? fixed_rsp : r);
      end
   endtask

   // Stops offering pixels and waits until every expected result has come,
   // then lets the pipeline settle so that a trailing pixel is fully absorbed.
   task automatic wait_drained();
      int waited;
      waited    = 0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         note_failure($sformatf("%0d expected results never arrived",
                                pending_results.size()));
         pending_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register. The valid is left high so that back-to-back writes
   // never lower and raise it in the same time step; the caller drops it.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DISTANCE_THRESHOLD: thr_q   = value;
         CSR_ENTER_PATTERN:      enter_q = value[PATTERN_WIDTH-1:0];
         CSR_EXIT_PATTERN:       exit_q  = value[PATTERN_WIDTH-1:0];
         CSR_DEFAULT_PATTERN:    dflt_q  = value[PATTERN_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Loads a full register setting once the core is idle. Pattern writes carry
   // random junk in the unused upper data bits, which must be dropped.
   task automatic load_setting(input logic [DIST_WIDTH-1:0] thr,
                               input logic [PATTERN_WIDTH-1:0] enter_pat,
                               input logic [PATTERN_WIDTH-1:0] exit_pat,
                               input logic [PATTERN_WIDTH-1:0] dflt_pat);
      logic [CSR_DATA_WIDTH-PATTERN_WIDTH-1:0] junk;
      wait_drained();
      write_register(CSR_DISTANCE_THRESHOLD, thr);
      junk = (CSR_DATA_WIDTH - PATTERN_WIDTH)'($urandom());
      write_register(CSR_ENTER_PATTERN, {junk, enter_pat});
      junk = (CSR_DATA_WIDTH - PATTERN_WIDTH)'($urandom());
      write_register(CSR_EXIT_PATTERN, {junk, exit_pat});
      junk = (CSR_DATA_WIDTH - PATTERN_WIDTH)'($urandom());
      write_register(CSR_DEFAULT_PATTERN, {junk, dflt_pat});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Sends a frame of a few pixels whose zone code comes out as wanted: one
   // forced near pixel per wanted zone, the rest random but never near in an
   // unwanted zone. Now and then a full sixteen-pixel frame is sent instead.
   task automatic send_frame(input zone_type want);
      zone_type     zones;
      int           n;
      int           pos_l;
      int           pos_r;
      int           thr_i;
      bit           near;
      bit           right_zone;
      req_data_type px;
      thr_i = int'(thr_q);
      zones = (thr_i == 0) ? ZONE_EMPTY : want;
      n     = ($urandom_range(0, 9) == 0) ? 2 * PIXELS_PER_ZONE : $urandom_range(1, 5);
      if (zones == ZONE_BOTH && n < 2) n = 2;
      pos_l = zones[0] ? $urandom_range(0, n - 1) : -1;
      pos_r = -1;
      if (zones[1]) begin
         do pos_r = $urandom_range(0, n - 1); while (pos_r == pos_l);
      end
      for (int i = 0; i < n; i++) begin
         if (i == pos_l) begin
            px.pixel_index = PIXEL_WIDTH'($urandom_range(0, PIXELS_PER_ZONE - 1));
         end else if (i == pos_r) begin
            px.pixel_index = PIXEL_WIDTH'($urandom_range(PIXELS_PER_ZONE,
                                                         2 * PIXELS_PER_ZONE - 1));
         end else if (n == 2 * PIXELS_PER_ZONE) begin
            px.pixel_index = PIXEL_WIDTH'(i);
         end else begin
            px.pixel_index = PIXEL_WIDTH'($urandom_range(0, 2 * PIXELS_PER_ZONE - 1));
         end
         right_zone = (px.pixel_index >= PIXELS_PER_ZONE);
         near = (i == pos_l) || (i == pos_r) ||
                (zones[right_zone] && $urandom_range(0, 1) == 1);
         px.range_mm  = DIST_WIDTH'(near ? $urandom_range(0, thr_i - 1)
                                         : $urandom_range(thr_i, 4095));
         px.frame_end = (i == n - 1);
         send_pixel(px, 1'b0, '0);
      end
   endtask

   // A frame of entirely random pixels, closed by the last one.
   task automatic send_noise_frame();
      int           n;
      req_data_type px;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         px.range_mm    = DIST_WIDTH'($urandom_range(0, 4095));
         px.pixel_index = PIXEL_WIDTH'($urandom_range(0, 15));
         px.frame_end   = (i == n - 1);
         send_pixel(px, 1'b0, '0);
      end
   endtask

   // Replays the codes of a crossing sequence after the empty start entry,
   // closing with an empty frame. A broken walk swaps one code for a random
   // one; occasionally a frame is repeated, which must change nothing.
   task automatic walk_sequence(input logic [PATTERN_WIDTH-1:0] pat, input bit broken);
      int       bad;
      zone_type code;
      bad  = broken ? $urandom_range(1, PATTERN_ENTRIES - 1) : 0;
      code = ZONE_EMPTY;
      for (int k = 1; k < PATTERN_ENTRIES; k++) begin
         code = pattern_code(pat, k);
         if (k == bad) code = zone_type'($urandom_range(0, 3));
         send_frame(code);
         if ($urandom_range(0, 7) == 0) send_frame(code);
      end
      if (code != ZONE_EMPTY) send_frame(ZONE_EMPTY);
   endtask

   // Mostly well-formed enter and exit walks with random pixel content, the
   // rest noise frames and random code runs.
   task automatic run_random(input int count);
      int stop;
      stop = items_sent + count;
      while (items_sent < stop) begin
         case ($urandom_range(0, 9))
            0, 1:    send_noise_frame();
            2, 3, 4: walk_sequence(enter_q, $urandom_range(0, 4) == 0);
            5, 6, 7: walk_sequence(exit_q, $urandom_range(0, 4) == 0);
            default: begin
               repeat ($urandom_range(1, 5)) send_frame(zone_type'($urandom_range(0, 3)));
            end
         endcase
      end
   endtask

   // Receiver side: random stall bursts, with calm stretches between.
   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run--;
      end else if (calm_run > 0) begin
         calm_run--;
      end else if (idle_on && !reset) begin
         case ($urandom_range(0, 19))
            0, 1, 2: stall_run = $urandom_range(1, 9);
            3:       calm_run  = $urandom_range(20, 60);
            default: ;
         endcase
      end
      rsp_stall <= (stall_run > 0);
   end

   // Result checker: every accepted result transaction is compared with the
   // oldest outstanding prediction, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_result = rsp_data;
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result event=%0d zone=%0d",
                                   got_result.crossing_event, got_result.zone_code));
         end else begin
            want_result = pending_results.pop_front();
            if (got_result.crossing_event !== want_result.crossing_event ||
                got_result.zone_code !== want_result.zone_code) begin
               note_failure($sformatf(
                  "result %0d: expected event=%0d zone=%0d, got event=%0d zone=%0d",
                  results_seen, want_result.crossing_event, want_result.zone_code,
                  got_result.crossing_event, got_result.zone_code));
            end
            if (got_result.crossing_event == EVENT_ENTER) enters_seen++;
            if (got_result.crossing_event == EVENT_EXIT)  exits_seen++;
         end
         results_seen++;
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tof_doorway_direction_detector_core_tb NOT OK");
      $finish;
   end

   initial begin
      int per_phase;
      per_phase = RANDOM_ITEMS / PHASE_COUNT;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table with the register defaults in force.
      foreach (DIRECTED[i]) begin
         send_pixel(DIRECTED[i].px, DIRECTED[i].fixed, DIRECTED[i].want);
      end

      // Highest threshold: every distance but the saturated one is near.
      load_setting(12'd4095, ENTER_RESET, EXIT_RESET, DEFAULT_RESET);
      run_random(per_phase);

      // Zero threshold: nothing is ever near; extreme pattern values.
      load_setting(12'd0, 10'd0, 10'h3FF, 10'h3FF);
      run_random(per_phase);

      // Identical enter and exit sequences, so enter must take priority.
      // Half way through, the sender holds off until the core has drained.
      load_setting(DIST_WIDTH'($urandom_range(1, 4095)), ENTER_RESET, ENTER_RESET,
                   DEFAULT_RESET);
      run_random(per_phase / 2);
      wait_drained();
      run_random(per_phase - per_phase / 2);

      // Fully random setting, including a non-empty default history.
      load_setting(DIST_WIDTH'($urandom_range(0, 4095)),
                   PATTERN_WIDTH'($urandom_range(0, 1023)),
                   PATTERN_WIDTH'($urandom_range(0, 1023)),
                   PATTERN_WIDTH'($urandom_range(0, 1023)));
      run_random(per_phase);

      // Lowest useful threshold with the two sequences swapped.
      load_setting(12'd1, EXIT_RESET, ENTER_RESET, DEFAULT_RESET);
      run_random(per_phase);

      // Back to the defaults for a last stretch at full rate on both sides.
      load_setting(THRESHOLD_RESET, ENTER_RESET, EXIT_RESET, DEFAULT_RESET);
      idle_on = 1'b0;
      run_random(RANDOM_ITEMS - 5 * per_phase);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Ran %0d pixel transactions giving %0d frame results under %0d settings.",
               items_sent, results_seen, settings_used);
      $display("Crossings reported: %0d enter, %0d exit; %0d failures.",
               enters_seen, exits_seen, fail_count);
      if (fail_count == 0) begin
         $display("tof_doorway_direction_detector_core_tb OK");
      end else begin
         $display("tof_doorway_direction_detector_core_tb NOT OK");
      end
      $finish;
   end

endmodule

[tof_doorway_direction_detector_core.f]
rtl/tdd_pkg.sv
rtl/tof_doorway_direction_detector_core.sv
bench/tof_doorway_direction_detector_core_tb.sv
